### hw/rtl/fpes_pkg.sv
// types and constants shared by the flash program and erase sequencer
`default_nettype none

package fpes_pkg;

   localparam int ADDR_W   = 24;
   localparam int COUNT_W  = 24;
   localparam int STATUS_W = 8;
   localparam int LEN_W    = 9;

   // status register one: write in progress
   localparam int STATUS_BUSY_BIT = 0;
   localparam logic [1:0] WORD_MASK = 2'h3;
   localparam logic [LEN_W-1:0] CHUNK_CAP = 9'd256;

   typedef enum logic [1:0] {
      OPC_START_WRITE = 2'd0,
      OPC_START_ERASE = 2'd1,
      OPC_TICK        = 2'd2,
      OPC_XFER_ERROR  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_START     = 3'd1,
      PH_WAIT_TX   = 3'd2,
      PH_WAIT_BUSY = 3'd3,
      PH_ERROR     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      OK_NONE  = 2'd0,
      OK_WRITE = 2'd1,
      OK_ERASE = 2'd2
   } op_kind_type;

   typedef enum logic [2:0] {
      RC_IDLE   = 3'd0,
      RC_BUSY   = 3'd1,
      RC_DONE   = 3'd2,
      RC_ERROR  = 3'd3,
      RC_ACCEPT = 3'd4,
      RC_REJECT = 3'd5
   } result_code_type;

   // request payload, first field in the highest bits
   typedef struct packed {
      logic                transfer_done;
      logic                command_ok;
      logic                write_enable_ok;
      logic [STATUS_W-1:0] flash_status;
      logic [COUNT_W-1:0]  byte_count;
      logic [ADDR_W-1:0]   start_address;
   } req_fields_type;

   // response payload, first field in the highest bits
   typedef struct packed {
      logic              word_aligned;
      logic [LEN_W-1:0]  program_length;
      logic [ADDR_W-1:0] command_address;
      logic              issue_erase;
      logic              issue_program;
      result_code_type   result_code;
   } rsp_fields_type;

   localparam int REQ_BITS = $bits(req_fields_type);
   localparam int RSP_BITS = $bits(rsp_fields_type);
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

### hw/rtl/flash_program_erase_sequencer.sv
// top level of the serial nor flash page program and sector erase sequencer
`default_nettype none

// Serial NOR flash sequencer: each request beat carries one event (start write,
// start sector erase, status tick or transfer error) and yields exactly one
// response beat with a result code and any page program or erase command to
// issue. A beat passes an input register, combinational decision logic on the
// job registers and an output register, so one beat is taken every cycle when
// the response side is ready; the job state registers update in the same
// cycle that decides the beat, which sets the one-beat-per-cycle rate. Writes
// are cut into chunks that never cross a page and never exceed 256 bytes.
// PAGE_BYTES and SECTOR_BYTES must be powers of two; the user must write
// device_present only while no beat is in flight, the block does not enforce it.
module flash_program_erase_sequencer
   import fpes_pkg::*;
#(
   parameter int PAGE_BYTES   = 256,
   parameter int SECTOR_BYTES = 4096,
   parameter int FLASH_BYTES  = 8388608
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_wdata,      // device_present
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // start_address, byte_count, flash_status, write_enable_ok, command_ok,
   // transfer_done, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,      // opcode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // result_code, issue_program, issue_erase, command_address,
   // program_length, word_aligned, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int PAGE_W  = $clog2(PAGE_BYTES);
   localparam int CHUNK_W = PAGE_W + 1;

   logic            device_present_ff;
   logic            in_valid_ff;
   req_fields_type  in_data_ff;
   opcode_type      in_op_ff;
   logic            out_valid_ff;
   rsp_fields_type  out_data_ff;

   phase_type            phase_ff, phase_in;
   op_kind_type          kind_ff, kind_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [COUNT_W-1:0]   left_ff, left_in;
   logic [LEN_W-1:0]     chunk_ff, chunk_in;
   rsp_fields_type       out_data_in;

   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_BITS){1'b0}}, out_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         device_present_ff <= 1'b0;
      end else if (csr_we) begin
         device_present_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_fields_type'(req_tdata[REQ_BITS-1:0]);
         in_op_ff   <= opcode_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= OK_NONE;
         addr_ff  <= '0;
         left_ff  <= '0;
         chunk_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
         chunk_ff <= chunk_in;
      end
   end

   always_comb begin
      logic                  busy;
      logic                  running;
      logic                  do_tick;
      logic                  done;
      logic                  reject;
      logic [ADDR_W:0]       end_addr;
      logic [ADDR_W-1:0]     aligned;
      logic [CHUNK_W-1:0]    chunk_raw;
      logic [COUNT_W-1:0]    chunk_wide;
      logic [LEN_W-1:0]      chunk;
      result_code_type       tick_rc;

      phase_in    = phase_ff;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      left_in     = left_ff;
      chunk_in    = chunk_ff;
      out_data_in = '0;
      out_data_in.result_code = RC_IDLE;
      tick_rc     = RC_IDLE;
      do_tick     = 1'b0;
      done        = 1'b0;
      reject      = 1'b0;
      busy        = in_data_ff.flash_status[STATUS_BUSY_BIT];
      running     = (phase_ff == PH_START) || (phase_ff == PH_WAIT_TX)
                    || (phase_ff == PH_WAIT_BUSY);
      end_addr    = {1'b0, in_data_ff.start_address} + {1'b0, in_data_ff.byte_count};
      aligned     = in_data_ff.start_address & ~ADDR_W'(SECTOR_BYTES - 1);

      case (in_op_ff)
         OPC_START_WRITE: begin
            reject = !device_present_ff || (in_data_ff.byte_count == '0)
                     || (end_addr > (ADDR_W+1)'(FLASH_BYTES)) || running;
            if (!reject) begin
               kind_in  = OK_WRITE;
               addr_in  = in_data_ff.start_address;
               left_in  = in_data_ff.byte_count;
               chunk_in = '0;
               phase_in = PH_START;
               do_tick  = 1'b1;
            end
         end
         OPC_START_ERASE: begin
            reject = !device_present_ff
                     || ({1'b0, in_data_ff.start_address} >= (ADDR_W+1)'(FLASH_BYTES))
                     || running || busy || !in_data_ff.write_enable_ok
                     || !in_data_ff.command_ok;
            if (!reject) begin
               kind_in  = OK_ERASE;
               phase_in = PH_WAIT_BUSY;
               addr_in  = aligned;
               chunk_in = '0;
               left_in  = '0;
               out_data_in.issue_erase     = 1'b1;
               out_data_in.command_address = aligned;
            end
         end
         OPC_TICK: begin
            do_tick = 1'b1;
         end
         OPC_XFER_ERROR: begin
            if (phase_ff != PH_IDLE) begin
               phase_in = PH_ERROR;
               tick_rc  = RC_ERROR;
            end
         end
         default: begin
         end
      endcase

      // chunk up to the next page boundary, then limited by bytes left and the cap
      chunk_raw  = CHUNK_W'(PAGE_BYTES) - {1'b0, addr_in[PAGE_W-1:0]};
      chunk_wide = (COUNT_W'(chunk_raw) > left_in) ? left_in : COUNT_W'(chunk_raw);
      chunk      = (chunk_wide > COUNT_W'(CHUNK_CAP)) ? CHUNK_CAP : chunk_wide[LEN_W-1:0];

      if (do_tick) begin
         if (!device_present_ff) begin
            tick_rc = RC_ERROR;
         end else begin
            case (phase_in)
               PH_START: begin
                  if (kind_in != OK_WRITE) begin
                     phase_in = PH_ERROR;
                  end else if (!busy) begin
                     if (!in_data_ff.write_enable_ok || !in_data_ff.command_ok) begin
                        phase_in = PH_ERROR;
                     end else begin
                        out_data_in.issue_program   = 1'b1;
                        out_data_in.command_address = addr_in;
                        out_data_in.program_length  = chunk;
                        out_data_in.word_aligned    = ((chunk[1:0] & WORD_MASK) == 2'b00);
                        chunk_in = chunk;
                        phase_in = PH_WAIT_TX;
                     end
                  end
               end
               PH_WAIT_TX: begin
                  if (kind_in != OK_WRITE) begin
                     phase_in = PH_ERROR;
                  end else if (in_data_ff.transfer_done) begin
                     phase_in = PH_WAIT_BUSY;
                  end
               end
               PH_WAIT_BUSY: begin
                  if (!busy) begin
                     if (kind_in == OK_ERASE) begin
                        done = 1'b1;
                     end else begin
                        addr_in  = addr_in + ADDR_W'(chunk_in);
                        left_in  = left_in - COUNT_W'(chunk_in);
                        chunk_in = '0;
                        if (left_in == '0) begin
                           done = 1'b1;
                        end else begin
                           phase_in = PH_START;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase

            if (done) begin
               phase_in = PH_IDLE;
               kind_in  = OK_NONE;
               tick_rc  = RC_DONE;
            end else if (phase_in == PH_ERROR) begin
               phase_in = PH_IDLE;
               kind_in  = OK_NONE;
               tick_rc  = RC_ERROR;
            end else if ((phase_in != PH_START) && (phase_in != PH_WAIT_TX)
                         && (phase_in != PH_WAIT_BUSY)) begin
               phase_in = PH_IDLE;
               kind_in  = OK_NONE;
               tick_rc  = RC_IDLE;
            end else begin
               tick_rc = RC_BUSY;
            end
         end
      end

      if (in_op_ff == OPC_START_WRITE) begin
         if (reject || (tick_rc == RC_ERROR)) begin
            out_data_in.result_code = RC_REJECT;
         end else begin
            out_data_in.result_code = RC_ACCEPT;
         end
      end else if (in_op_ff == OPC_START_ERASE) begin
         out_data_in.result_code = reject ? RC_REJECT : RC_ACCEPT;
      end else begin
         out_data_in.result_code = tick_rc;
      end
   end

`ifndef SYNTH
   // an idle sequencer never keeps a job kind
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (kind_ff == OK_NONE))
      else $error("idle phase with a job kind still set");

   // an issued page program carries a non-empty chunk within the cap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data_ff.issue_program) |->
         ((out_data_ff.program_length != '0) && (out_data_ff.program_length <= CHUNK_CAP)))
      else $error("page program chunk length out of range");

   // a command is only issued alongside an accepting or busy answer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_data_ff.issue_program || out_data_ff.issue_erase)) |->
         ((out_data_ff.result_code == RC_ACCEPT) || (out_data_ff.result_code == RC_BUSY)))
      else $error("command issued with a failing result code");

   // a decided beat with a stalled response must not be lost
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && !advance) || rsp_tready || advance)
      else $error("response beat dropped while stalled");
`endif

endmodule

`default_nettype wire
